// ----- hw/rtl/lac_pkg.sv -----
// ============================================================================
// lac_pkg: shared types, constants and helpers for the LoRa airtime core
// Holds the register codes, the fixed-point widths and the small tables
// used by the symbol, scaling and divider stages.
// ============================================================================
`default_nettype none

package lac_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SPREADING_FACTOR = 2'd0,
    CFG_BANDWIDTH_HZ     = 2'd1,
    CFG_CODING_RATE      = 2'd2,
    CFG_UNUSED           = 2'd3
  } cfg_index_t;

  localparam int SF_W   = 4;
  localparam int BW_W   = 19;
  localparam int CR_W   = 3;
  localparam int BYTE_W = 8;

  localparam logic [SF_W-1:0] SF_MIN   = 4'd5;
  localparam logic [SF_W-1:0] SF_MAX   = 4'd12;
  localparam logic [SF_W-1:0] SF_RESET = 4'd7;
  localparam logic [BW_W-1:0] BW_RESET = 19'd125000;
  localparam logic [CR_W-1:0] CR_RESET = 3'd1;

  // Quarter-symbol count: 97 + 4 * payload symbols, at most 7665
  localparam int QTR_W = 13;
  localparam logic [QTR_W-1:0] FIXED_QUARTERS = 13'd97;

  // Quarter symbols times one million
  localparam int US_W = 20;
  localparam logic [US_W-1:0] US_PER_SECOND = 20'd1000000;
  localparam int MUL_W = 33;

  // Rounded-division numerator 2N + BW and divisor 2 * BW
  localparam int NUM_W = 44;
  localparam int QUO_W = 32;
  localparam int REM_W = BW_W + 1;
  localparam int HI_W  = NUM_W - QUO_W;

  localparam int DIV_STEP_BITS = 2;

  // Reciprocal of (SF - 2) scaled by 2^16, rounded up
  localparam int RCP_W     = 15;
  localparam int RCP_SHIFT = 16;

  localparam logic [QUO_W-1:0] RESULT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic              ovf;
    logic [REM_W-1:0]  rem;
    logic [QUO_W-1:0]  lo;
  } div_beat_t;

  function automatic logic [SF_W-1:0] clamp_sf(input logic [SF_W-1:0] sf);
    logic [SF_W-1:0] res;
    begin
      res = sf;
      if (sf < SF_MIN) res = SF_MIN;
      if (sf > SF_MAX) res = SF_MAX;
      return res;
    end
  endfunction

  function automatic logic [RCP_W-1:0] sf_recip(input logic [SF_W-1:0] sf);
    logic [RCP_W-1:0] res;
    begin
      case (sf)
        4'd5:    res = 15'd21846;
        4'd6:    res = 15'd16384;
        4'd7:    res = 15'd13108;
        4'd8:    res = 15'd10923;
        4'd9:    res = 15'd9363;
        4'd10:   res = 15'd8192;
        4'd11:   res = 15'd7282;
        4'd12:   res = 15'd6554;
        default: res = 15'd6554;
      endcase
      return res;
    end
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lac_symbols.sv -----
// ============================================================================
// lac_symbols: packet symbol count in quarter-symbol units
// Two stages: block count by reciprocal multiply, then coding-rate scaling
// plus the fixed preamble, sync and header part.
// ============================================================================
`default_nettype none

module lac_symbols (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_vld,
  input  wire logic [lac_pkg::BYTE_W-1:0]    in_bytes,
  input  wire logic [lac_pkg::SF_W-1:0]      sf,
  input  wire logic [lac_pkg::CR_W-1:0]      cr,
  output logic                               qtr_vld,
  output logic [lac_pkg::QTR_W-1:0]          qtr
);

  localparam int X_W    = 10;
  localparam int PROD_W = X_W + lac_pkg::RCP_W;
  localparam int BLK_W  = 8;
  localparam int PAY_W  = 11;

  logic                          vld_a_r;
  logic [PROD_W-1:0]             prod_r, prod_nxt;
  logic                          vld_b_r;
  logic [lac_pkg::QTR_W-1:0]     qtr_r, qtr_nxt;

  logic [X_W-1:0]                pos;
  logic [X_W-1:0]                ceil_num;
  logic [BLK_W-1:0]              blocks;
  logic [PAY_W-1:0]              pay;

  // With the quarter folded in, the ceiling numerator is 2n + 8 and the
  // payload is empty when 2n + 11 does not exceed SF.
  always_comb begin
    pos      = {1'b0, in_bytes, 1'b0} + 10'd11;
    ceil_num = {1'b0, in_bytes, 1'b0} + 10'd8;
    if (pos <= {6'd0, sf}) begin
      prod_nxt = '0;
    end else begin
      prod_nxt = ceil_num * lac_pkg::sf_recip(sf);
    end
  end

  always_comb begin
    blocks  = prod_r[lac_pkg::RCP_SHIFT +: BLK_W];
    pay     = blocks * ({1'b0, cr} + 4'd4);
    qtr_nxt = lac_pkg::FIXED_QUARTERS + {pay, 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      vld_a_r <= in_vld;
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    qtr_r  <= qtr_nxt;
  end

  assign qtr_vld = vld_b_r;
  assign qtr     = qtr_r;

endmodule

`default_nettype wire

// ----- hw/rtl/lac_scale.sv -----
// ============================================================================
// lac_scale: build the rounded-division numerator and set up the divider
// Three stages: multiply by one million, shift by SF - 1 and add the
// bandwidth, then check for quotient overflow and load the remainder.
// ============================================================================
`default_nettype none

module lac_scale (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          qtr_vld,
  input  wire logic [lac_pkg::QTR_W-1:0]     qtr,
  input  wire logic [lac_pkg::SF_W-1:0]      sf,
  input  wire logic [lac_pkg::BW_W-1:0]      bw,
  output logic                               beat_vld,
  output lac_pkg::div_beat_t                 beat
);

  logic                          vld_c_r, vld_d_r, vld_e_r;
  logic [lac_pkg::MUL_W-1:0]     mul_r, mul_nxt;
  logic [lac_pkg::NUM_W-1:0]     num_r, num_nxt;
  lac_pkg::div_beat_t            beat_r, beat_nxt;

  logic [lac_pkg::SF_W-1:0]      shamt;
  logic [lac_pkg::HI_W-1:0]      hi;
  logic [lac_pkg::REM_W-1:0]     divisor;

  always_comb begin
    mul_nxt = qtr * lac_pkg::US_PER_SECOND;
    shamt   = sf - 4'd1;
    num_nxt = ({{(lac_pkg::NUM_W-lac_pkg::MUL_W){1'b0}}, mul_r} << shamt)
              + {{(lac_pkg::NUM_W-lac_pkg::BW_W){1'b0}}, bw};
  end

  // Quotient overflows 32 bits when the top bits already reach the divisor;
  // a zero bandwidth always lands here.
  always_comb begin
    hi           = num_r[lac_pkg::NUM_W-1 -: lac_pkg::HI_W];
    divisor      = {bw, 1'b0};
    beat_nxt.ovf = ({{(lac_pkg::REM_W-lac_pkg::HI_W){1'b0}}, hi} >= divisor);
    beat_nxt.rem = {{(lac_pkg::REM_W-lac_pkg::HI_W){1'b0}}, hi};
    beat_nxt.lo  = num_r[lac_pkg::QUO_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c_r <= 1'b0;
      vld_d_r <= 1'b0;
      vld_e_r <= 1'b0;
    end else begin
      vld_c_r <= qtr_vld;
      vld_d_r <= vld_c_r;
      vld_e_r <= vld_d_r;
    end
  end

  always_ff @(posedge clk) begin
    mul_r  <= mul_nxt;
    num_r  <= num_nxt;
    beat_r <= beat_nxt;
  end

  assign beat_vld = vld_e_r;
  assign beat     = beat_r;

endmodule

`default_nettype wire

// ----- hw/rtl/lac_div_stage.sv -----
// ============================================================================
// lac_div_stage: one registered slice of the restoring divider
// Retires STEP_BITS quotient bits; quotient bits shift into the low word as
// the dividend bits shift out.
// ============================================================================
`default_nettype none

module lac_div_stage #(
  parameter int STEP_BITS = lac_pkg::DIV_STEP_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_vld,
  input  wire lac_pkg::div_beat_t            in_beat,
  input  wire logic [lac_pkg::BW_W-1:0]      bw,
  output logic                               out_vld,
  output lac_pkg::div_beat_t                 out_beat
);

  logic                  vld_r;
  lac_pkg::div_beat_t    beat_r, beat_nxt;

  always_comb begin
    logic [lac_pkg::REM_W:0]    trial;
    logic [lac_pkg::REM_W:0]    divisor;
    logic                       qbit;
    beat_nxt = in_beat;
    divisor  = {1'b0, bw, 1'b0};
    for (int i = 0; i < STEP_BITS; i++) begin
      trial = {beat_nxt.rem, beat_nxt.lo[lac_pkg::QUO_W-1]};
      qbit  = (trial >= divisor);
      if (qbit) begin
        trial = trial - divisor;
      end
      beat_nxt.rem = trial[lac_pkg::REM_W-1:0];
      beat_nxt.lo  = {beat_nxt.lo[lac_pkg::QUO_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
  end

  assign out_vld  = vld_r;
  assign out_beat = beat_r;

endmodule

`default_nettype wire

// ----- hw/rtl/lora_airtime_calculator_core.sv -----
// ============================================================================
// lora_airtime_calculator_core: LoRa time on air in microseconds
// Fully pipelined: one packet length per cycle in, one rounded, saturated
// airtime per cycle out.
// ============================================================================
//
//  Channel  | Ports                                  | Beat marker
//  ---------+----------------------------------------+-------------------------
//  input    | in_packet_bytes[7:0]                   | start high, busy low
//  result   | out_airtime_us[31:0]                   | out_valid, one cycle
//  config   | cfg_index[1:0], cfg_wdata[18:0]        | cfg_we
//
//  The pipeline is the symbol and scaling stages, then the divider slices,
//  each retiring STEP_BITS quotient bits per cycle, then the output register.
//  Throughput is one beat per cycle; busy is never raised.
//  The receiver cannot stall, so the pipeline advances every cycle.
//  Synchronous reset clears the valid bits and loads the register defaults
//  (SF 7, 125 kHz, coding rate 4/5); payload registers are not reset.
//  Change configuration only while no beat is in flight.
//
// ============================================================================
`default_nettype none

module lora_airtime_calculator_core #(
  parameter int STEP_BITS = lac_pkg::DIV_STEP_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [lac_pkg::BYTE_W-1:0]    in_packet_bytes,
  // result channel
  output logic                               out_valid,
  output logic [lac_pkg::QUO_W-1:0]          out_airtime_us,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [lac_pkg::BW_W-1:0]      cfg_wdata
);

  localparam int DIV_STAGES = lac_pkg::QUO_W / STEP_BITS;

  // Configuration registers
  logic [lac_pkg::SF_W-1:0]      sf_r, sf_nxt;
  logic [lac_pkg::BW_W-1:0]      bw_r, bw_nxt;
  logic [lac_pkg::CR_W-1:0]      cr_r, cr_nxt;
  logic [lac_pkg::SF_W-1:0]      sf_eff;

  // Pipeline links
  logic                          accept;
  logic                          qtr_vld;
  logic [lac_pkg::QTR_W-1:0]     qtr;
  logic                          div_vld  [DIV_STAGES+1];
  lac_pkg::div_beat_t            div_beat [DIV_STAGES+1];

  // Output register
  logic                          out_valid_r, out_valid_nxt;
  logic [lac_pkg::QUO_W-1:0]     out_airtime_r, out_airtime_nxt;

  // Decode register writes; an index past the list writes nothing
  always_comb begin
    sf_nxt = sf_r;
    bw_nxt = bw_r;
    cr_nxt = cr_r;
    if (cfg_we) begin
      case (lac_pkg::cfg_index_t'(cfg_index))
        lac_pkg::CFG_SPREADING_FACTOR: sf_nxt = cfg_wdata[lac_pkg::SF_W-1:0];
        lac_pkg::CFG_BANDWIDTH_HZ:     bw_nxt = cfg_wdata;
        lac_pkg::CFG_CODING_RATE:      cr_nxt = cfg_wdata[lac_pkg::CR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sf_r <= lac_pkg::SF_RESET;
      bw_r <= lac_pkg::BW_RESET;
      cr_r <= lac_pkg::CR_RESET;
    end else begin
      sf_r <= sf_nxt;
      bw_r <= bw_nxt;
      cr_r <= cr_nxt;
    end
  end

  // Out-of-range spreading factors pin to the nearest legal value
  assign sf_eff = lac_pkg::clamp_sf(sf_r);

  // Every start is taken; the pipeline never backs up
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Quarter-symbol count of the whole packet
  lac_symbols u_symbols (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (accept),
    .in_bytes (in_packet_bytes),
    .sf       (sf_eff),
    .cr       (cr_r),
    .qtr_vld  (qtr_vld),
    .qtr      (qtr)
  );

  // Numerator 2 * Q * 2^(SF-2) * 1e6 + BW over divisor 2 * BW gives the
  // half-up rounded microsecond count
  lac_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .qtr_vld  (qtr_vld),
    .qtr      (qtr),
    .sf       (sf_eff),
    .bw       (bw_r),
    .beat_vld (div_vld[0]),
    .beat     (div_beat[0])
  );

  // Divider chain, STEP_BITS quotient bits per slice
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    lac_div_stage #(
      .STEP_BITS (STEP_BITS)
    ) u_div_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (div_vld[g]),
      .in_beat  (div_beat[g]),
      .bw       (bw_r),
      .out_vld  (div_vld[g+1]),
      .out_beat (div_beat[g+1])
    );
  end

  // Saturate on quotient overflow, which also covers a zero bandwidth
  always_comb begin
    out_valid_nxt   = div_vld[DIV_STAGES];
    out_airtime_nxt = div_beat[DIV_STAGES].ovf ? lac_pkg::RESULT_MAX
                                               : div_beat[DIV_STAGES].lo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_airtime_r <= out_airtime_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_airtime_us = out_airtime_r;

endmodule

`default_nettype wire

// ----- bench/lora_airtime_calculator_core_tb.sv -----
// ============================================================================
// lora_airtime_calculator_core_tb: self-checking bench for the airtime core
// Drives packet lengths under a series of register settings, predicts each
// rounded, saturated airtime in exact 64-bit integer math and compares every
// result beat, in order, with the oldest pending prediction.
// ============================================================================

module lora_airtime_calculator_core_tb;

  import lac_pkg::*;

  // Pipeline depth at the default divider step; used for end-of-run settling
  localparam int PIPE_LAT    = 22;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_ITEMS  = 1530;
  localparam int DIR_N       = 21;

  // One row of the directed table. When reconf is set, drain the pipeline and
  // load sf/bw/cr before sending the row. When known is set, the expected
  // airtime is typed in; otherwise the predictor supplies it.
  typedef struct packed {
    logic              reconf;
    logic [SF_W-1:0]   sf;
    logic [BW_W-1:0]   bw;
    logic [CR_W-1:0]   cr;
    logic [BYTE_W-1:0] bytes;
    logic              known;
    logic [QUO_W-1:0]  airtime;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [BYTE_W-1:0]   in_packet_bytes;
  logic                out_valid;
  logic [QUO_W-1:0]    out_airtime_us;
  logic                cfg_we;
  logic [1:0]          cfg_index;
  logic [BW_W-1:0]     cfg_wdata;

  // Bench copy of the three registers, updated at each accepted write
  logic [SF_W-1:0]     sf_q;
  logic [BW_W-1:0]     bw_q;
  logic [CR_W-1:0]     cr_q;

  logic [QUO_W-1:0]    airtime_due_q[$];
  dir_row_t            dir_tab[DIR_N];
  int                  mismatches;
  int                  cycle_count;

  lora_airtime_calculator_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_packet_bytes (in_packet_bytes),
    .out_valid       (out_valid),
    .out_airtime_us  (out_airtime_us),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // --------------------------------------------------------------------------
  // Airtime predictor: quarter symbols Q = 97 + 4 * payload symbols, then
  // Q * 2^SF * 1e6 / (4 * BW), rounded half up and clipped to 32 bits.
  // --------------------------------------------------------------------------
  function automatic logic [QUO_W-1:0] predict_airtime(input logic [BYTE_W-1:0] n,
                                                       input logic [SF_W-1:0] sf_raw,
                                                       input logic [BW_W-1:0] bw,
                                                       input logic [CR_W-1:0] cr);
    logic [SF_W-1:0] sf;
    int unsigned     pos;
    int unsigned     neg;
    int unsigned     blk_den;
    int unsigned     payload;
    int unsigned     quarters;
    logic [63:0]     num;
    logic [63:0]     den;
    logic [63:0]     quo;
    begin
      // Zero bandwidth means an infinite airtime: pin to all ones
      if (bw == '0) return RESULT_MAX;
      // Hold SF inside 5..12
      sf = sf_raw;
      if (sf_raw < SF_MIN) sf = SF_MIN;
      else if (sf_raw > SF_MAX) sf = SF_MAX;
      pos     = 32'(n) * 8 + 44;
      neg     = 32'(sf) * 4;
      blk_den = (32'(sf) - 2) * 4;
      // Short payloads at high SF fit in the header block: no payload symbols
      if (pos <= neg) payload = 0;
      else payload = ((pos - neg + blk_den - 1) / blk_den) * (32'(cr) + 4);
      quarters = 32'(FIXED_QUARTERS) + 4 * payload;
      num = 64'(quarters) * (64'd1 << sf) * 64'(US_PER_SECOND);
      den = 64'(bw) * 4;
      quo = (2 * num + den) / (2 * den);
      if (quo > 64'(RESULT_MAX)) return RESULT_MAX;
      return quo[QUO_W-1:0];
    end
  endfunction

  task automatic log_mismatch(input string what, input logic [QUO_W-1:0] want,
                              input logic [QUO_W-1:0] got);
    begin
      mismatches++;
      if (mismatches <= 10)
        $display("%s: expected %0d (0x%08h), got %0d (0x%08h)", what, want, want, got, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // Input driver. Inputs change on the falling edge; a beat counts at the
  // rising edge where start is high and busy is low. Leave start high after
  // a beat so back-to-back beats need only one assignment per edge.
  // --------------------------------------------------------------------------
  task automatic send_packet(input logic [BYTE_W-1:0] bytes, input logic known,
                             input logic [QUO_W-1:0] airtime);
    begin
      @(negedge clk);
      start           <= 1'b1;
      in_packet_bytes <= bytes;
      @(posedge clk);
      while (busy) @(posedge clk);
      // Beat taken: queue what it must produce, using the registers now live
      airtime_due_q.push_back(known ? airtime : predict_airtime(bytes, sf_q, bw_q, cr_q));
    end
  endtask

  task automatic idle_gap(input int n);
    begin
      repeat (n) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
  endtask

  // Drop start and hold until every queued airtime has come back
  task automatic wait_drain();
    begin
      @(negedge clk);
      start <= 1'b0;
      while (airtime_due_q.size() != 0) @(posedge clk);
    end
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [BW_W-1:0] data);
    begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= data;
      @(posedge clk);
      // Only the low bits of the SF and CR words are kept; the spare index is dropped
      case (idx)
        CFG_SPREADING_FACTOR: sf_q = data[SF_W-1:0];
        CFG_BANDWIDTH_HZ:     bw_q = data;
        CFG_CODING_RATE:      cr_q = data[CR_W-1:0];
        default: ;
      endcase
    end
  endtask

  // Load a full setting while the pipeline is empty. Pad the narrow registers
  // with random upper bits and poke the unused index, both of which the core
  // must ignore.
  task automatic program_regs(input logic [SF_W-1:0] sf, input logic [BW_W-1:0] bw,
                              input logic [CR_W-1:0] cr);
    logic [BW_W-1:0] sf_word;
    logic [BW_W-1:0] cr_word;
    begin
      sf_word             = BW_W'($urandom);
      sf_word[SF_W-1:0]   = sf;
      cr_word             = BW_W'($urandom);
      cr_word[CR_W-1:0]   = cr;
      wait_drain();
      write_reg(CFG_SPREADING_FACTOR, sf_word);
      write_reg(CFG_BANDWIDTH_HZ, bw);
      write_reg(CFG_CODING_RATE, cr_word);
      write_reg(CFG_UNUSED, BW_W'($urandom));
      @(negedge clk);
      cfg_we <= 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checker: the receiver cannot stall, so take every strobed beat and
  // compare it with the oldest pending airtime.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (airtime_due_q.size() == 0) begin
        log_mismatch("unexpected result beat", '0, out_airtime_us);
      end else begin
        if (out_airtime_us !== airtime_due_q[0])
          log_mismatch("airtime_us mismatch", airtime_due_q[0], out_airtime_us);
        void'(airtime_due_q.pop_front());
      end
    end
  end

  // Watchdog: stop a hung run well past the slowest legal finish
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    dir_row_t        row;
    int              sent;
    int              plen;
    int              kind;
    int              i;
    bit              paused_once;
    bit              quiet;
    logic [SF_W-1:0] rsf;
    logic [BW_W-1:0] rbw;
    logic [CR_W-1:0] rcr;
    logic [BYTE_W-1:0] rbytes;

    // Every input known from time zero
    rst_n           = 1'b0;
    start           = 1'b0;
    in_packet_bytes = '0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_SPREADING_FACTOR;
    cfg_wdata       = '0;
    mismatches      = 0;
    cycle_count     = 0;
    paused_once     = 1'b0;
    sf_q            = 4'd7;
    bw_q            = 19'd125000;
    cr_q            = 3'd1;

    // Directed table:   reconf sf     bw            cr     bytes     known airtime
    // Defaults, empty packet: 117 quarters * 128 * 1e6 / 500000 = 29952 exactly
    dir_tab[0]  = '{1'b0, 4'd7,  19'd125000, 3'd1, 8'd0,   1'b1, 32'd29952};
    dir_tab[1]  = '{1'b0, 4'd7,  19'd125000, 3'd1, 8'd255, 1'b0, 32'd0};
    dir_tab[2]  = '{1'b0, 4'd7,  19'd125000, 3'd1, 8'd1,   1'b0, 32'd0};
    // Fastest corner
    dir_tab[3]  = '{1'b1, 4'd5,  19'd500000, 3'd1, 8'd0,   1'b0, 32'd0};
    dir_tab[4]  = '{1'b0, 4'd5,  19'd500000, 3'd1, 8'd255, 1'b0, 32'd0};
    // Slowest in-range corner; an empty packet at SF 12 has no payload symbols
    dir_tab[5]  = '{1'b1, 4'd12, 19'd7800,   3'd4, 8'd0,   1'b0, 32'd0};
    dir_tab[6]  = '{1'b0, 4'd12, 19'd7800,   3'd4, 8'd1,   1'b0, 32'd0};
    dir_tab[7]  = '{1'b0, 4'd12, 19'd7800,   3'd4, 8'd255, 1'b0, 32'd0};
    // SF below and above range is clamped
    dir_tab[8]  = '{1'b1, 4'd0,  19'd125000, 3'd1, 8'd20,  1'b0, 32'd0};
    dir_tab[9]  = '{1'b1, 4'd15, 19'd125000, 3'd4, 8'd20,  1'b0, 32'd0};
    // Zero bandwidth reads as infinite time
    dir_tab[10] = '{1'b1, 4'd7,  19'd0,      3'd1, 8'd0,   1'b1, 32'hFFFF_FFFF};
    dir_tab[11] = '{1'b0, 4'd7,  19'd0,      3'd1, 8'd255, 1'b1, 32'hFFFF_FFFF};
    // 1 Hz at SF 12 overflows 32 bits and saturates
    dir_tab[12] = '{1'b1, 4'd12, 19'd1,      3'd4, 8'd255, 1'b1, 32'hFFFF_FFFF};
    dir_tab[13] = '{1'b0, 4'd12, 19'd1,      3'd4, 8'd0,   1'b1, 32'hFFFF_FFFF};
    // Widest bandwidth word, coding rate past 4/8
    dir_tab[14] = '{1'b1, 4'd12, 19'd524287, 3'd7, 8'd255, 1'b0, 32'd0};
    // Bandwidth under range but nonzero, coding rate zero
    dir_tab[15] = '{1'b1, 4'd9,  19'd1000,   3'd0, 8'd100, 1'b0, 32'd0};
    dir_tab[16] = '{1'b1, 4'd6,  19'd62500,  3'd5, 8'd128, 1'b0, 32'd0};
    dir_tab[17] = '{1'b1, 4'd8,  19'd250000, 3'd2, 8'd85,  1'b0, 32'd0};
    dir_tab[18] = '{1'b1, 4'd10, 19'd41700,  3'd3, 8'd170, 1'b0, 32'd0};
    dir_tab[19] = '{1'b1, 4'd11, 19'd20800,  3'd6, 8'd64,  1'b0, 32'd0};
    // Back to the reset setting by explicit writes
    dir_tab[20] = '{1'b1, 4'd7,  19'd125000, 3'd1, 8'd0,   1'b1, 32'd29952};

    // Single reset pulse, released on a falling edge
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table back to back
    for (i = 0; i < DIR_N; i++) begin
      row = dir_tab[i];
      if (row.reconf) program_regs(row.sf, row.bw, row.cr);
      send_packet(row.bytes, row.known, row.airtime);
    end

    // Random phases: reload registers, then a burst of packet lengths
    sent = 0;
    while (sent < RAND_ITEMS) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        // Zero bandwidth now and then
        rsf = SF_W'($urandom);
        rbw = '0;
        rcr = CR_W'($urandom);
      end else if (kind <= 4) begin
        // Range extremes
        rsf = $urandom_range(0, 1) ? SF_MAX : SF_MIN;
        rbw = $urandom_range(0, 1) ? 19'd500000 : 19'd7800;
        rcr = $urandom_range(0, 1) ? 3'd4 : 3'd1;
      end else if (kind <= 8) begin
        // Any bit pattern the registers can hold
        rsf = SF_W'($urandom);
        rbw = BW_W'($urandom);
        rcr = CR_W'($urandom);
      end else begin
        rsf = SF_W'($urandom_range(5, 12));
        rbw = BW_W'($urandom_range(7800, 500000));
        rcr = CR_W'($urandom_range(1, 4));
      end
      program_regs(rsf, rbw, rcr);

      plen = $urandom_range(20, 90);
      for (i = 0; i < plen && sent < RAND_ITEMS; i++) begin
        // Once, stop feeding mid-phase until the pipeline has fully emptied
        if (!paused_once && sent >= 300) begin
          wait_drain();
          paused_once = 1'b1;
        end
        // Keep one long stretch free of gaps so the pipe runs full
        quiet = (sent >= 500 && sent < 850);
        if (!quiet && $urandom_range(0, 99) < 4)
          idle_gap(($urandom_range(0, 7) == 0) ? $urandom_range(4, 30) : $urandom_range(1, 3));
        if ($urandom_range(0, 7) == 0) rbytes = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        else rbytes = BYTE_W'($urandom);
        send_packet(rbytes, 1'b0, '0);
        sent++;
      end
    end

    // Drain, then settle past the pipeline depth to catch stray beats
    wait_drain();
    repeat (2 * PIPE_LAT) @(posedge clk);
    if (airtime_due_q.size() != 0) begin
      mismatches += airtime_due_q.size();
      $display("%0d results never arrived", airtime_due_q.size());
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/lac_pkg.sv
hw/rtl/lac_symbols.sv
hw/rtl/lac_scale.sv
hw/rtl/lac_div_stage.sv
hw/rtl/lora_airtime_calculator_core.sv
bench/lora_airtime_calculator_core_tb.sv
